// File: src/ael_pkg.sv
// Shared types, constants and character-class helpers for the expression lexer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ael_pkg;

    // Default width of the character position counters
    localparam int POS_WIDTH_DEF = 16;

    // Widths of the result fields
    localparam int KIND_W  = 4;
    localparam int FIELD_W = 16;
    localparam int CHAR_W  = 8;

    // Most results one input beat can release, and the result queue depth
    localparam int MAX_RES   = 3;
    localparam int RES_DEPTH = 4;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 4'd0,
        KIND_NUMBER = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_PLUS   = 4'd3,
        KIND_MINUS  = 4'd4,
        KIND_TIMES  = 4'd5,
        KIND_DIVIDE = 4'd6,
        KIND_OPEN   = 4'd7,
        KIND_CLOSE  = 4'd8,
        KIND_BAD    = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [FIELD_W-1:0]  start;
        logic [FIELD_W-1:0]  length;
        logic [CHAR_W-1:0]   bad;
        logic                last;
    } t_result;

    // Results released by one beat, in order, slots below cnt valid
    typedef struct packed {
        logic [1:0]                cnt;
        t_result [MAX_RES-1:0]     res;
    } t_push;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // Operator kind of a character, KIND_END when it is no operator
    function automatic t_kind op_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_TIMES;
            CH_SLASH: k = KIND_DIVIDE;
            CH_OPEN:  k = KIND_OPEN;
            CH_CLOSE: k = KIND_CLOSE;
            default:  k = KIND_END;
        endcase
        return k;
    endfunction

    // Clamp a position or length to the 16-bit result field
    function automatic logic [FIELD_W-1:0] sat16(input logic [31:0] v);
        return (v[31:FIELD_W] != '0) ? '1 : v[FIELD_W-1:0];
    endfunction

endpackage

// File: src/ael_core.sv
// Scan state and token decision logic: one character beat in, up to three results out.
// Depends on ael_pkg.
`timescale 1ns / 1ps

module ael_core #(
    parameter int POS_WIDTH = ael_pkg::POS_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_beat,
    input  logic [ael_pkg::CHAR_W-1:0]  i_symbol,
    input  logic                        i_is_end,
    output ael_pkg::t_push              o_push
);
    import ael_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_NUM    = 6'b000010,
        MODE_HELD_E = 6'b000100,
        MODE_EXP    = 6'b001000,
        MODE_IDENT  = 6'b010000,
        MODE_ERROR  = 6'b100000
    } t_mode;

    t_mode                r_mode,  n_mode;
    logic [POS_WIDTH-1:0] r_pos,   n_pos;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic [POS_WIDTH-1:0] r_held,  n_held;

    logic [POS_WIDTH-1:0] sp_cur, sp_num_e, sp_held;
    logic                 b_valid, b_setst;
    t_mode                b_mode;
    t_result              b_res;
    logic                 va, vb, vc;
    t_result              ra, rb, rc;
    logic [CHAR_W-1:0]    c;

    function automatic t_result mk_tok(input t_kind k, input logic [POS_WIDTH-1:0] st,
                                       input logic [POS_WIDTH-1:0] len);
        t_result r;
        r.kind   = k;
        r.start  = sat16(32'(st));
        r.length = sat16(32'(len));
        r.bad    = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] from,
                                                  input logic [POS_WIDTH-1:0] upto);
        return (upto >= from) ? upto - from : '0;
    endfunction

    assign c        = i_symbol;
    assign sp_cur   = span(r_start, r_pos);
    assign sp_num_e = span(r_start, r_held);
    assign sp_held  = span(r_held, r_pos);

    // Start a new token at the current character
    always_comb begin
        b_valid      = 1'b0;
        b_setst      = 1'b0;
        b_mode       = MODE_IDLE;
        b_res        = mk_tok(op_kind(c), r_pos, POS_WIDTH'(1));
        if (is_space(c)) begin
            b_mode = MODE_IDLE;
        end else if (op_kind(c) != KIND_END) begin
            b_valid = 1'b1;
        end else if (is_digit(c) || c == CH_DOT) begin
            b_mode  = MODE_NUM;
            b_setst = 1'b1;
        end else if (is_alpha(c)) begin
            b_mode  = MODE_IDENT;
            b_setst = 1'b1;
        end else begin
            b_valid    = 1'b1;
            b_mode     = MODE_ERROR;
            b_res.kind = KIND_BAD;
            b_res.bad  = c;
            b_res.last = 1'b1;
        end
    end

    // Decide results and next scan state for this beat
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_held  = r_held;
        va = 1'b0;
        vb = 1'b0;
        vc = 1'b0;
        ra = mk_tok(KIND_NUMBER, r_start, sp_cur);
        rb = mk_tok(KIND_IDENT, r_held, sp_held);
        rc = b_res;
        if (i_is_end) begin
            // Flush any pending tokens, close the text unless an error token did, return to reset state
            case (r_mode)
                MODE_NUM, MODE_EXP: va = 1'b1;
                MODE_IDENT: begin
                    va = 1'b1;
                    ra = mk_tok(KIND_IDENT, r_start, sp_cur);
                end
                MODE_HELD_E: begin
                    va = 1'b1;
                    vb = 1'b1;
                    ra = mk_tok(KIND_NUMBER, r_start, sp_num_e);
                end
                default: ;
            endcase
            vc      = (r_mode != MODE_ERROR);
            rc      = mk_tok(KIND_END, r_pos, '0);
            rc.last = 1'b1;
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_held  = '0;
        end else begin
            if (r_pos != '1) begin
                n_pos = r_pos + POS_WIDTH'(1);
            end
            case (r_mode)
                MODE_IDLE: begin
                    vc     = b_valid;
                    n_mode = b_mode;
                    if (b_setst) n_start = r_pos;
                end
                MODE_NUM: begin
                    if (is_digit(c) || c == CH_DOT) begin
                        n_mode = MODE_NUM;
                    end else if (c == CH_E_LO || c == CH_E_UP) begin
                        n_mode = MODE_HELD_E;
                        n_held = r_pos;
                    end else begin
                        va     = 1'b1;
                        vc     = b_valid;
                        n_mode = b_mode;
                        if (b_setst) n_start = r_pos;
                    end
                end
                MODE_HELD_E: begin
                    if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
                        n_mode = MODE_EXP;
                    end else begin
                        // Number ends before the 'e', which opens an identifier
                        va      = 1'b1;
                        ra      = mk_tok(KIND_NUMBER, r_start, sp_num_e);
                        n_start = r_held;
                        n_mode  = MODE_IDENT;
                        if (!(is_alpha(c) || is_digit(c))) begin
                            vb     = 1'b1;
                            vc     = b_valid;
                            n_mode = b_mode;
                            if (b_setst) n_start = r_pos;
                        end
                    end
                end
                MODE_EXP: begin
                    if (!is_digit(c)) begin
                        va     = 1'b1;
                        vc     = b_valid;
                        n_mode = b_mode;
                        if (b_setst) n_start = r_pos;
                    end
                end
                MODE_IDENT: begin
                    if (!(is_alpha(c) || is_digit(c))) begin
                        va     = 1'b1;
                        ra     = mk_tok(KIND_IDENT, r_start, sp_cur);
                        vc     = b_valid;
                        n_mode = b_mode;
                        if (b_setst) n_start = r_pos;
                    end
                end
                default: n_mode = MODE_ERROR;
            endcase
        end
    end

    // Pack results in order; a second result implies a first
    always_comb begin
        o_push.res[0] = va ? ra : rc;
        o_push.res[1] = vb ? rb : rc;
        o_push.res[2] = rc;
        o_push.cnt    = i_beat ? ({1'b0, va} + {1'b0, vb} + {1'b0, vc}) : 2'd0;
    end

    // Advance scan state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_held  <= '0;
        end else if (i_beat) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_held  <= n_held;
        end
    end

    // Error mode swallows characters without results
    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && !i_is_end && r_mode == MODE_ERROR) |-> (o_push.cnt == 2'd0))
        else $error("result released in error mode");

    // End of text returns the scanner to its reset state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_is_end) |=> (r_mode == MODE_IDLE && r_pos == '0))
        else $error("scanner not reset after end of text");

endmodule

// File: src/ael_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per beat.
// Depends on ael_pkg.
`timescale 1ns / 1ps

module ael_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ael_pkg::t_push   i_push,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output ael_pkg::t_result o_head
);
    import ael_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_result              r_mem [RES_DEPTH];
    logic [PTR_W-1:0]     r_wr, n_wr;
    logic [PTR_W-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // Hold off input unless a full burst of results fits
    assign o_full  = (r_count > CNT_W'(RES_DEPTH - MAX_RES));

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.cnt);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Write the released results at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_push.cnt)) begin
                r_mem[PTR_W'(r_wr + PTR_W'(k))] <= i_push.res[k];
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_count) + 4'(i_push.cnt)) <= (4'(RES_DEPTH) + 4'(pop)))
        else $error("result queue overflow");

    a_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

// File: src/arithmetic_expression_lexer.sv
// Arithmetic expression lexer: character stream in, token descriptors out.
// Instantiates ael_core and ael_fifo; depends on ael_pkg.
//
// Usage:
//   Input channel: one character per beat on i_symbol, or an end-of-text
//   marker with i_is_end high. A beat is taken when i_valid is high and
//   o_stall is low. Output channel: one token per beat on o_kind,
//   o_token_start, o_token_length, o_bad_char and o_last, taken when o_valid
//   is high and i_stall is low. o_last closes each text (end or error token).
//   Tokens are registered into the result queue. Throughput: one character
//   per cycle while o_stall is low; a beat can release up to three tokens,
//   which drain one per cycle while i_stall is low through a four-entry
//   result queue. o_stall rises whenever the queue holds two or more tokens,
//   so a burst or a stalling receiver pauses the input until the queue
//   drains. While the receiver stalls, the head token holds steady. Reset
//   (synchronous, active low) empties the queue and returns the scanner to
//   idle at position zero; the end marker returns only the scanner there.
`timescale 1ns / 1ps

module arithmetic_expression_lexer #(
    parameter int POS_WIDTH = ael_pkg::POS_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ael_pkg::CHAR_W-1:0]   i_symbol,
    input  logic                         i_is_end,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ael_pkg::KIND_W-1:0]   o_kind,
    output logic [ael_pkg::FIELD_W-1:0]  o_token_start,
    output logic [ael_pkg::FIELD_W-1:0]  o_token_length,
    output logic [ael_pkg::CHAR_W-1:0]   o_bad_char,
    output logic                         o_last
);
    import ael_pkg::*;

    logic    beat;
    logic    full;
    t_push   push;
    t_result head;

    assign o_stall = full;
    assign beat    = i_valid && !full;

    ael_core #(
        .POS_WIDTH(POS_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .i_symbol (i_symbol),
        .i_is_end (i_is_end),
        .o_push   (push)
    );

    ael_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    // Drive the result fields from the queue head
    assign o_kind         = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_bad_char     = head.bad;
    assign o_last         = head.last;

endmodule

// File: tb/ael_checker.sv
`timescale 1ns / 1ps
// Token checker for the expression lexer: watches the character and token channels,
// predicts every token from the accepted characters and compares field by field.
// Depends on ael_pkg for kind codes, the result struct and character constants.

module ael_checker #(
    parameter int POS_WIDTH = ael_pkg::POS_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [ael_pkg::CHAR_W-1:0]  i_symbol,
    input  logic                        i_is_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [ael_pkg::KIND_W-1:0]  i_kind,
    input  logic [ael_pkg::FIELD_W-1:0] i_token_start,
    input  logic [ael_pkg::FIELD_W-1:0] i_token_length,
    input  logic [ael_pkg::CHAR_W-1:0]  i_bad_char,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_pending
);
    import ael_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_HELD_E,
        SCAN_EXPONENT,
        SCAN_IDENT,
        SCAN_ERROR
    } t_scan;

    localparam logic [POS_WIDTH-1:0] POS_TOP = '1;

    // Scanner copy: mode, next offset, start of the open token, offset of a held e
    t_scan                scan;
    logic [POS_WIDTH-1:0] pos;
    logic [POS_WIDTH-1:0] tok_start;
    logic [POS_WIDTH-1:0] e_at;

    t_result token_q[$];
    int      fails = 0;

    function automatic logic digit_ch(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic name_ch(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic blank_ch(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic t_kind op_of(input logic [CHAR_W-1:0] c);
        case (c)
            CH_PLUS:  return KIND_PLUS;
            CH_MINUS: return KIND_MINUS;
            CH_STAR:  return KIND_TIMES;
            CH_SLASH: return KIND_DIVIDE;
            CH_OPEN:  return KIND_OPEN;
            CH_CLOSE: return KIND_CLOSE;
            default:  return KIND_END;
        endcase
    endfunction

    function automatic logic [31:0] span_of(input logic [POS_WIDTH-1:0] from,
                                            input logic [POS_WIDTH-1:0] upto);
        return (upto >= from) ? 32'(upto) - 32'(from) : 32'd0;
    endfunction

    function automatic logic [FIELD_W-1:0] clip(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? '1 : v[FIELD_W-1:0];
    endfunction

    task automatic add_token(input t_kind k, input logic [31:0] start,
                             input logic [31:0] len, input logic [CHAR_W-1:0] bad,
                             input logic fin);
        t_result r;
        r.kind   = k;
        r.start  = clip(start);
        r.length = clip(len);
        r.bad    = bad;
        r.last   = fin;
        token_q  = {token_q, r};
    endtask

    task automatic clear_scan();
        scan      = SCAN_IDLE;
        pos       = '0;
        tok_start = '0;
        e_at      = '0;
    endtask

    // Classify a character seen between tokens
    task automatic open_token(input logic [CHAR_W-1:0] ch, input logic [POS_WIDTH-1:0] at);
        t_kind op;
        op   = op_of(ch);
        scan = SCAN_IDLE;
        if (blank_ch(ch)) begin
            // drop whitespace
        end else if (op != KIND_END) begin
            add_token(op, at, 32'd1, '0, 1'b0);
        end else if (digit_ch(ch) || ch == CH_DOT) begin
            scan      = SCAN_NUMBER;
            tok_start = at;
        end else if (name_ch(ch)) begin
            scan      = SCAN_IDENT;
            tok_start = at;
        end else begin
            add_token(KIND_BAD, at, 32'd1, ch, 1'b1);
            scan = SCAN_ERROR;
        end
    endtask

    // Advance the scanner by one accepted beat and queue the tokens it closes
    task automatic lex_beat(input logic [CHAR_W-1:0] ch, input logic eot);
        logic [POS_WIDTH-1:0] at;
        at = pos;
        if (eot) begin
            case (scan)
                SCAN_NUMBER, SCAN_EXPONENT: begin
                    add_token(KIND_NUMBER, tok_start, span_of(tok_start, at), '0, 1'b0);
                end
                SCAN_IDENT: begin
                    add_token(KIND_IDENT, tok_start, span_of(tok_start, at), '0, 1'b0);
                end
                SCAN_HELD_E: begin
                    add_token(KIND_NUMBER, tok_start, span_of(tok_start, e_at), '0, 1'b0);
                    add_token(KIND_IDENT, e_at, span_of(e_at, at), '0, 1'b0);
                end
                default: begin
                end
            endcase
            // an error token has already closed the text
            if (scan != SCAN_ERROR) begin
                add_token(KIND_END, at, 32'd0, '0, 1'b1);
            end
            clear_scan();
        end else begin
            if (pos != POS_TOP) begin
                pos = pos + 1'b1;
            end
            case (scan)
                SCAN_IDLE: begin
                    open_token(ch, at);
                end
                SCAN_NUMBER: begin
                    if (ch == CH_E_LO || ch == CH_E_UP) begin
                        scan = SCAN_HELD_E;
                        e_at = at;
                    end else if (!digit_ch(ch) && ch != CH_DOT) begin
                        add_token(KIND_NUMBER, tok_start, span_of(tok_start, at), '0, 1'b0);
                        open_token(ch, at);
                    end
                end
                SCAN_HELD_E: begin
                    if (digit_ch(ch) || ch == CH_PLUS || ch == CH_MINUS) begin
                        scan = SCAN_EXPONENT;
                    end else begin
                        // no exponent: the number ends before the e, which starts a name
                        add_token(KIND_NUMBER, tok_start, span_of(tok_start, e_at), '0, 1'b0);
                        tok_start = e_at;
                        scan      = SCAN_IDENT;
                        if (!name_ch(ch) && !digit_ch(ch)) begin
                            add_token(KIND_IDENT, e_at, span_of(e_at, at), '0, 1'b0);
                            open_token(ch, at);
                        end
                    end
                end
                SCAN_EXPONENT: begin
                    if (!digit_ch(ch)) begin
                        add_token(KIND_NUMBER, tok_start, span_of(tok_start, at), '0, 1'b0);
                        open_token(ch, at);
                    end
                end
                SCAN_IDENT: begin
                    if (!name_ch(ch) && !digit_ch(ch)) begin
                        add_token(KIND_IDENT, tok_start, span_of(tok_start, at), '0, 1'b0);
                        open_token(ch, at);
                    end
                end
                default: begin
                    scan = SCAN_ERROR;
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fails++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Compare the token beat first, then predict from the character beat
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_scan();
            token_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (token_q.size() == 0) begin
                    fails++;
                    $error("kind: expected no token, got %0d", i_kind);
                end else begin
                    want = token_q.pop_front();
                    check_field("kind", want.kind, i_kind);
                    check_field("token_start", want.start, i_token_start);
                    check_field("token_length", want.length, i_token_length);
                    check_field("bad_char", want.bad, i_bad_char);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                lex_beat(i_symbol, i_is_end);
            end
        end
        o_fail_count <= fails;
        o_pending    <= token_q.size();
    end

endmodule

// File: tb/arithmetic_expression_lexer_test.sv
`timescale 1ns / 1ps
// Testbench top for the expression lexer: clock, reset, character texts and receiver
// stalls, with the verdict at the end. Depends on ael_pkg, the lexer and ael_checker.

module arithmetic_expression_lexer_test;
    import ael_pkg::*;

    // Letters and underscore lead the name set, digits follow
    localparam int NAME_LEAD = 53;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CHAR_W-1:0]  symbol    = '0;
    logic               is_end    = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [CHAR_W-1:0]  bad_char;
    logic               tok_last;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int beats     = 0;
    int idle_tab[4]  = '{0, 65, 0, 32};
    int stall_tab[4] = '{0, 0, 65, 32};

    string name_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string op_set    = "+-*/()";
    string blank_set = " \t\n\r";
    string junk_set  = "#!?@$%&^~`=<>,;:'\"[]{}|\\";

    arithmetic_expression_lexer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_symbol       (symbol),
        .i_is_end       (is_end),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_kind         (kind),
        .o_token_start  (token_start),
        .o_token_length (token_length),
        .o_bad_char     (bad_char),
        .o_last         (tok_last)
    );

    ael_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_symbol       (symbol),
        .i_is_end       (is_end),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_token_start  (token_start),
        .i_token_length (token_length),
        .i_bad_char     (bad_char),
        .i_last         (tok_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall at random at the current rate
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Present one beat, idling first at the sender rate; valid holds until taken
    task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= ch;
        is_end   <= eot;
        do @(posedge clk); while (in_stall);
        beats++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(s[k], 1'b0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_junk();
        case ($urandom_range(0, 2))
            0: send_beat(8'($urandom_range(128, 255)), 1'b0);
            1: send_beat(8'($urandom_range(0, 8)), 1'b0);
            default: send_beat(junk_set[$urandom_range(0, junk_set.len() - 1)], 1'b0);
        endcase
    endtask

    // One text of mostly well-formed tokens, sometimes pure noise, closed by the end marker
    task automatic send_random_text();
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // number: digits and dots, maybe an exponent in any state of completion
                    repeat ($urandom_range(1, 4)) begin
                        send_beat(($urandom_range(0, 5) == 0) ? CH_DOT
                                  : 8'h30 + 8'($urandom_range(0, 9)), 1'b0);
                    end
                    if ($urandom_range(0, 99) < 45) begin
                        send_beat($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
                        pick = $urandom_range(0, 99);
                        if (pick < 35) begin
                            send_beat($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
                        end else if (pick < 60) begin
                            send_beat(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
                        end else if (pick < 75) begin
                            send_beat(name_set[$urandom_range(0, NAME_LEAD - 1)], 1'b0);
                        end else if (pick < 90) begin
                            send_beat(op_set[$urandom_range(0, op_set.len() - 1)], 1'b0);
                        end
                        repeat ($urandom_range(0, 3)) begin
                            send_beat(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
                        end
                    end
                end else if (pick < 55) begin
                    send_beat(name_set[$urandom_range(0, NAME_LEAD - 1)], 1'b0);
                    repeat ($urandom_range(0, 4)) begin
                        send_beat(name_set[$urandom_range(0, name_set.len() - 1)], 1'b0);
                    end
                end else if (pick < 80) begin
                    send_beat(op_set[$urandom_range(0, op_set.len() - 1)], 1'b0);
                end else if (pick < 95) begin
                    send_beat(blank_set[$urandom_range(0, blank_set.len() - 1)], 1'b0);
                end else begin
                    send_junk();
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(blank_set[$urandom_range(0, blank_set.len() - 1)], 1'b0);
                end
            end
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operator, exponent forms, held e cases, errors, empty text
        send_text("7.5e+3*(x_1-.9)/Q\r");
        send_text("2e");
        send_text("4ez 6e-\n8e*");
        send_text("\t9E2)");
        send_text("");
        send_text("a?b");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h7F, 1'b1);
        send_beat(8'h01, 1'b0);
        send_beat(8'h00, 1'b1);

        // Random texts under each idling and receiver stall mix
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            target    = beats + 40;
            while (beats < target) begin
                send_random_text();
            end
        end

        // Drain every expected token, then let the block settle
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: arithmetic_expression_lexer.f
src/ael_pkg.sv
src/ael_core.sv
src/ael_fifo.sv
src/arithmetic_expression_lexer.sv
tb/ael_checker.sv
tb/arithmetic_expression_lexer_test.sv
